[design/hash_key_value_table_unit_assert.svh]
// Assertion macros for the checker file of the hash table unit.
// Each macro expects clk and arst_n in scope.
`ifndef HASH_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define HASH_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define HKV_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("hkv: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define HKV_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("hkv: next-cycle check failed");

`endif

[design/hkv_pkg.sv]
package hkv_pkg;

	// Default geometry of the table
	localparam int BUCKETS_DEF    = 256;
	localparam int WAYS_DEF       = 4;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed port widths
	localparam int ACTION_BITS     = 2;
	localparam int KEY_PORT_BITS   = 32;
	localparam int VALUE_PORT_BITS = 32;
	localparam int COUNT_BITS      = 11;

	// Entries in the queue between hashing and execution
	localparam int QUEUE_DEPTH = 4;

	typedef logic [ACTION_BITS-1:0] action_t;

	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_LOOKUP = 2'd1;
	localparam action_t ACT_ERASE  = 2'd2;
	localparam action_t ACT_CLEAR  = 2'd3;

	// Head of the request queue as seen by the execution side
	typedef struct packed {
		logic    valid;
		action_t action;
	} req_ctl_t;

endpackage

[design/hkv_front.sv]
module hkv_front #(
	parameter int BUCKETS = hkv_pkg::BUCKETS_DEF,
	parameter int KEY_BITS = hkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hkv_pkg::VALUE_BITS_DEF,
	localparam int KW = (KEY_BITS < hkv_pkg::KEY_PORT_BITS) ? KEY_BITS : hkv_pkg::KEY_PORT_BITS,
	localparam int VW = (VALUE_BITS < hkv_pkg::VALUE_PORT_BITS) ?
		VALUE_BITS : hkv_pkg::VALUE_PORT_BITS,
	localparam int BW = $clog2(BUCKETS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                hold,
	input  hkv_pkg::action_t                    action,
	input  logic [hkv_pkg::KEY_PORT_BITS-1:0]   key,
	input  logic [hkv_pkg::VALUE_PORT_BITS-1:0] value,
	output logic                                busy,
	output hkv_pkg::req_ctl_t                   head,
	output logic [KW-1:0]                       head_key,
	output logic [VW-1:0]                       head_value,
	output logic [BW-1:0]                       head_bucket,
	input  logic                                pop
);
	import hkv_pkg::*;

	// key mod BUCKETS by reciprocal: q = (key * RECIP) >> SHIFT is exact for KW-bit keys
	localparam int SHIFT = KW + BW;
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam int MW = KW + 1;
	localparam int PW = KW + MW;
	localparam int BBW = $clog2(BUCKETS + 1);
	localparam int QBW = KW + BBW;

	localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CTW = $clog2(QUEUE_DEPTH + 1);
	localparam int OW = $clog2(QUEUE_DEPTH + 3);

	logic            accept;
	logic [KW-1:0]   key_m;
	logic [PW-1:0]   prod;

	logic            v_s1;
	action_t         act_s1;
	logic [KW-1:0]   key_s1;
	logic [VW-1:0]   val_s1;
	logic [PW-1:0]   prod_s1;
	logic [KW-1:0]   quot;
	logic [QBW-1:0]  qprod;

	logic            v_s2;
	action_t         act_s2;
	logic [KW-1:0]   key_s2;
	logic [VW-1:0]   val_s2;
	logic [KW-1:0]   qb_s2;
	logic [KW-1:0]   rem;

	action_t         fifo_act_q [QUEUE_DEPTH];
	logic [KW-1:0]   fifo_key_q [QUEUE_DEPTH];
	logic [VW-1:0]   fifo_val_q [QUEUE_DEPTH];
	logic [BW-1:0]   fifo_bkt_q [QUEUE_DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CTW-1:0]  cnt_q;
	logic [OW-1:0]   occ;

	// Refuse a beat while hold is high or when the queue could not hold everything in flight
	assign occ = OW'(cnt_q) + OW'(v_s1) + OW'(v_s2);
	assign busy = hold || (occ >= OW'(QUEUE_DEPTH));
	assign accept = start && !busy;

	assign key_m = key[KW-1:0];
	assign prod = PW'(key_m) * PW'(RECIP[MW-1:0]);

	// Stage 1: capture the beat and the reciprocal product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= action;
			key_s1  <= key_m;
			val_s1  <= value[VW-1:0];
			prod_s1 <= prod;
		end
	end

	// Stage 2: quotient times bucket count
	assign quot = KW'(prod_s1 >> SHIFT);
	assign qprod = QBW'(quot) * QBW'(BUCKETS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			act_s2 <= act_s1;
			key_s2 <= key_s1;
			val_s2 <= val_s1;
			qb_s2  <= qprod[KW-1:0];
		end
	end

	// Remainder is the bucket index
	assign rem = key_s2 - qb_s2;

	// Push the hashed request into the queue
	always_ff @(posedge clk) begin
		if (v_s2) begin
			fifo_act_q[wr_ptr_q] <= act_s2;
			fifo_key_q[wr_ptr_q] <= key_s2;
			fifo_val_q[wr_ptr_q] <= val_s2;
			fifo_bkt_q[wr_ptr_q] <= BW'(rem);
		end
	end

	// Advance the queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CTW'(v_s2) - CTW'(pop);
		end
	end

	assign head.valid   = (cnt_q != '0);
	assign head.action  = fifo_act_q[rd_ptr_q];
	assign head_key     = fifo_key_q[rd_ptr_q];
	assign head_value   = fifo_val_q[rd_ptr_q];
	assign head_bucket  = fifo_bkt_q[rd_ptr_q];

endmodule

[design/hkv_back.sv]
module hkv_back #(
	parameter int BUCKETS = hkv_pkg::BUCKETS_DEF,
	parameter int WAYS = hkv_pkg::WAYS_DEF,
	parameter int KEY_BITS = hkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hkv_pkg::VALUE_BITS_DEF,
	localparam int KW = (KEY_BITS < hkv_pkg::KEY_PORT_BITS) ? KEY_BITS : hkv_pkg::KEY_PORT_BITS,
	localparam int VW = (VALUE_BITS < hkv_pkg::VALUE_PORT_BITS) ?
		VALUE_BITS : hkv_pkg::VALUE_PORT_BITS,
	localparam int BW = $clog2(BUCKETS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hkv_pkg::req_ctl_t                   head,
	input  logic [KW-1:0]                       head_key,
	input  logic [VW-1:0]                       head_value,
	input  logic [BW-1:0]                       head_bucket,
	output logic                                pop,
	output logic                                hold,
	output logic                                strobe,
	output logic                                found,
	output logic [hkv_pkg::VALUE_PORT_BITS-1:0] value_out,
	output logic [hkv_pkg::COUNT_BITS-1:0]      entry_count,
	output logic                                status
);
	import hkv_pkg::*;

	localparam int CNTW = $clog2(BUCKETS * WAYS + 1);
	localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_SWEEP = 2'd3;

	logic [1:0]         state_q;
	logic [BW-1:0]      sweep_q;
	logic [CNTW-1:0]    count_q;
	action_t            act_q;
	logic [KW-1:0]      key_q;
	logic [VW-1:0]      val_q;
	logic [BW-1:0]      bkt_q;

	logic [WAYS*KW-1:0] key_mem [BUCKETS];
	logic [WAYS*VW-1:0] val_mem [BUCKETS];
	logic [WAYS-1:0]    vld_mem [BUCKETS];
	logic [WAYS*KW-1:0] rd_keys_q;
	logic [WAYS*VW-1:0] rd_vals_q;
	logic [WAYS-1:0]    rd_valid_q;

	logic               strobe_q;
	logic               found_q;
	logic [VALUE_PORT_BITS-1:0] vout_q;
	logic               status_q;

	logic               sweeping;
	logic               in_exec;
	logic               is_ins;
	logic               is_lookup;
	logic               is_erase;
	logic [WAYS-1:0]    hit_vec;
	logic [WAYS-1:0]    free_vec;
	logic [WAYS-1:0]    hit_oh;
	logic [WAYS-1:0]    free_oh;
	logic [WAYS-1:0]    ins_oh;
	logic               hit_any;
	logic               free_any;
	logic [VW-1:0]      hit_val;
	logic [WAYS*KW-1:0] new_keys;
	logic [WAYS*VW-1:0] new_vals;
	logic [WAYS-1:0]    new_valid;
	logic               key_we;
	logic               val_we;
	logic               vld_we;
	logic [BW-1:0]      vld_addr;
	logic [WAYS-1:0]    vld_data;

	assign sweeping  = (state_q == ST_INIT) || (state_q == ST_SWEEP);
	assign in_exec   = (state_q == ST_EXEC);
	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign hold      = (state_q == ST_INIT);
	assign is_ins    = (act_q == ACT_INSERT);
	assign is_lookup = (act_q == ACT_LOOKUP);
	assign is_erase  = (act_q == ACT_ERASE);

	// Match the key against every way of the bucket row
	always_comb begin
		hit_vec = '0;
		hit_val = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = rd_valid_q[w] && (rd_keys_q[w*KW +: KW] == key_q);
		end
		free_vec = ~rd_valid_q;
		hit_oh   = hit_vec & ~(hit_vec - WAYS'(1));
		free_oh  = free_vec & ~(free_vec - WAYS'(1));
		hit_any  = |hit_vec;
		free_any = |free_vec;
		ins_oh   = hit_any ? hit_oh : free_oh;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_oh[w]) begin
				hit_val = hit_val | rd_vals_q[w*VW +: VW];
			end
		end
	end

	// Build the row written back
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			new_keys[w*KW +: KW] = (is_ins && !hit_any && free_oh[w]) ?
				key_q : rd_keys_q[w*KW +: KW];
			new_vals[w*VW +: VW] = (is_ins && ins_oh[w]) ? val_q : rd_vals_q[w*VW +: VW];
		end
		if (is_ins && !hit_any) begin
			new_valid = rd_valid_q | free_oh;
		end else if (is_erase) begin
			new_valid = rd_valid_q & ~hit_oh;
		end else begin
			new_valid = rd_valid_q;
		end
	end

	assign key_we   = in_exec && is_ins && !hit_any && free_any;
	assign val_we   = in_exec && is_ins && (hit_any || free_any);
	assign vld_we   = sweeping || (in_exec && (is_ins || is_erase));
	assign vld_addr = sweeping ? sweep_q : bkt_q;
	assign vld_data = sweeping ? '0 : new_valid;

	// Bucket memories: one row read on pop, one row written on execute or sweep
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_keys_q  <= key_mem[head_bucket];
			rd_vals_q  <= val_mem[head_bucket];
			rd_valid_q <= vld_mem[head_bucket];
		end
		if (key_we) begin
			key_mem[bkt_q] <= new_keys;
		end
		if (val_we) begin
			val_mem[bkt_q] <= new_vals;
		end
		if (vld_we) begin
			vld_mem[vld_addr] <= vld_data;
		end
	end

	// Latch the popped request
	always_ff @(posedge clk) begin
		if (pop) begin
			act_q <= head.action;
			key_q <= head_key;
			val_q <= head_value;
			bkt_q <= head_bucket;
		end
	end

	// Sequence sweep, pop and execute; update the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			sweep_q  <= '0;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_INIT, ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						if (head.action == ACT_CLEAR) begin
							count_q  <= '0;
							strobe_q <= 1'b1;
							sweep_q  <= '0;
							state_q  <= ST_SWEEP;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					strobe_q <= 1'b1;
					if (key_we) begin
						count_q <= count_q + 1'b1;
					end else if (is_erase && hit_any) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold result fields for the strobe cycle
	always_ff @(posedge clk) begin
		if (pop && head.action == ACT_CLEAR) begin
			found_q  <= 1'b0;
			vout_q   <= '0;
			status_q <= 1'b0;
		end else if (in_exec) begin
			found_q  <= hit_any;
			vout_q   <= (is_lookup && hit_any) ? VALUE_PORT_BITS'(hit_val) : '0;
			status_q <= is_ins && !hit_any && !free_any;
		end
	end

	assign strobe      = strobe_q;
	assign found       = found_q;
	assign value_out   = vout_q;
	assign status      = status_q;
	assign entry_count = COUNT_BITS'(count_q);

endmodule

[design/hash_key_value_table_unit.sv]
// Hashed key-value table, BUCKETS buckets of WAYS entries each.
// Request channel: action, key and value are taken at a rising edge where
// start is high and busy is low. Actions: insert or update, lookup, erase,
// clear all.
// Result channel: found, value_out, entry_count and status are valid for
// the single cycle in which strobe is high. The receiver cannot stall; every
// request yields exactly one result, in request order.
// From an accepted beat on an idle unit, the accepting edge loads the
// first hashing stage, then follow the second hashing stage, the queue, a
// bucket row read, then the compare and write-back, where strobe rises.
// Requests execute one at a time: a further request is popped only after
// the read-modify-write of one bucket row in the memories is complete.
// A clear gives its result at the edge that pops it and then sweeps the
// valid bits of all BUCKETS rows; requests queue up meanwhile and busy rises
// once the 4-entry queue is committed.
// Reset: the count clears at once and the valid bits of all BUCKETS rows
// are swept, with busy held high for that whole sweep.
module hash_key_value_table_unit #(
	parameter int BUCKETS = hkv_pkg::BUCKETS_DEF,
	parameter int WAYS = hkv_pkg::WAYS_DEF,
	parameter int KEY_BITS = hkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hkv_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  hkv_pkg::action_t                    action,
	input  logic [hkv_pkg::KEY_PORT_BITS-1:0]   key,
	input  logic [hkv_pkg::VALUE_PORT_BITS-1:0] value,
	output logic                                strobe,
	output logic                                found,
	output logic [hkv_pkg::VALUE_PORT_BITS-1:0] value_out,
	output logic [hkv_pkg::COUNT_BITS-1:0]      entry_count,
	output logic                                status
);
	import hkv_pkg::*;

	localparam int KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
	localparam int VW = (VALUE_BITS < VALUE_PORT_BITS) ? VALUE_BITS : VALUE_PORT_BITS;
	localparam int BW = $clog2(BUCKETS);

	req_ctl_t      head;
	logic [KW-1:0] head_key;
	logic [VW-1:0] head_value;
	logic [BW-1:0] head_bucket;
	logic          pop;
	logic          hold;

	// Accept and hash
	hkv_front #(
		.BUCKETS(BUCKETS),
		.KEY_BITS(KEY_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.hold(hold),
		.action(action),
		.key(key),
		.value(value),
		.busy(busy),
		.head(head),
		.head_key(head_key),
		.head_value(head_value),
		.head_bucket(head_bucket),
		.pop(pop)
	);

	// Execute against the bucket memories
	hkv_back #(
		.BUCKETS(BUCKETS),
		.WAYS(WAYS),
		.KEY_BITS(KEY_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_key(head_key),
		.head_value(head_value),
		.head_bucket(head_bucket),
		.pop(pop),
		.hold(hold),
		.strobe(strobe),
		.found(found),
		.value_out(value_out),
		.entry_count(entry_count),
		.status(status)
	);

endmodule

[design/hkv_checker.sv]
`include "hash_key_value_table_unit_assert.svh"

module hkv_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                strobe,
	input logic                                found,
	input logic [hkv_pkg::VALUE_PORT_BITS-1:0] value_out,
	input logic [hkv_pkg::COUNT_BITS-1:0]      entry_count,
	input logic                                status
);
	import hkv_pkg::*;

	// A refused insert never reports a hit
	`HKV_ASSERT_IMP(a_refused_not_found, strobe && status, !found)

	// A nonzero value only comes from a lookup hit
	`HKV_ASSERT_IMP(a_value_needs_hit, strobe && (value_out != '0), found)

	// The count moves only together with a result
	`HKV_ASSERT_IMP(a_count_quiet, !strobe, $stable(entry_count))

	// A result changes the count by at most one, or clears it
	`HKV_ASSERT_IMP(a_count_step, strobe, (entry_count == $past(entry_count)) || (entry_count == $past(entry_count) + 11'd1) || (entry_count == $past(entry_count) - 11'd1) || (entry_count == 11'd0))

	// Two refused inserts cannot come in consecutive cycles
	`HKV_ASSERT_NXT(a_refused_spacing, strobe && status, !(strobe && status))

endmodule

bind hash_key_value_table_unit hkv_checker u_hkv_checker (.*);
